### hw/rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on the given clock and
// disabled while the given active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, ck, rn, expr)
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

### hw/rtl/gjs_pkg.sv
`default_nettype none
package gjs_pkg;

	typedef enum logic [1:0] {
		MODE_LEFT  = 2'd0,
		MODE_RIGHT = 2'd1,
		MODE_DRAIN = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_ACCEPT = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_GROUP  = 2'd2,
		STAT_NONE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL_GO,
		ST_MUL,
		ST_RESP
	} gjs_state_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LO,
		MP_HI
	} mul_phase_t;

	localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] row_key;
		logic signed [31:0] row_value;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] group_key;
		logic signed [63:0] group_total;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] sum;
		logic [30:0] count;
		logic        has_left;
	} entry_t;

endpackage
`default_nettype wire

### hw/rtl/group_join_sum_engine.sv
// Channel  Dir  Payload               Handshake
// item     in   gjs_pkg::in_item_t    item_valid / item_stall
// result   out  gjs_pkg::out_item_t   result_valid / result_stall
//
// One item at a time. A left row or right key scans the occupied slots one
// per cycle through the table memory read port, stopping at a matching key.
// A drain scans from the drain pointer to the next match and on to the one
// after it; if it found a match it then runs the shared 32x31 multiplier.
// Reset clears slot count, drain pointer and control state, not the table.
// A stalled result waits in the output register while the next item runs.
`default_nettype none
`include "assert_macros.svh"
module group_join_sum_engine #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire gjs_pkg::in_item_t  item,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output gjs_pkg::out_item_t      result
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	gjs_pkg::gjs_state_t state_q, state_d;
	gjs_pkg::in_item_t   req_q;
	gjs_pkg::out_item_t  res_q, out_q;
	gjs_pkg::entry_t     rd_entry, wr_entry, hit_q, mod_entry, new_entry;
	logic                out_valid_q;
	logic [CW-1:0]       used_q, dp_q, scan_idx_q, rd_idx_q, wr_idx;
	logic                rv_q, found_q;
	logic                mem_we;
	logic                is_drain, scan_end, lk_hit, dr_match, second;
	logic                mul_start, mul_done;
	logic [63:0]         mul_product;
	logic [63:0]         sval;

	assign is_drain = req_q.mode == gjs_pkg::MODE_DRAIN;
	assign scan_end = scan_idx_q >= used_q;
	assign lk_hit = rv_q && (rd_entry.key == req_q.row_key);
	assign dr_match = rv_q && rd_entry.has_left && (rd_entry.count != '0);
	assign second = found_q && dr_match;
	assign sval = {{32{req_q.row_value[31]}}, req_q.row_value};
	assign mul_start = state_q == gjs_pkg::ST_MUL_GO;

	always_comb begin
		mod_entry = rd_entry;
		if (req_q.mode == gjs_pkg::MODE_LEFT) begin
			mod_entry.sum = rd_entry.sum + sval;
			mod_entry.has_left = 1'b1;
		end else if (rd_entry.count != gjs_pkg::COUNT_MAX) begin
			mod_entry.count = rd_entry.count + 31'd1;
		end
		new_entry.key = req_q.row_key;
		new_entry.has_left = req_q.mode == gjs_pkg::MODE_LEFT;
		new_entry.sum = (req_q.mode == gjs_pkg::MODE_LEFT) ? sval : 64'd0;
		new_entry.count = (req_q.mode == gjs_pkg::MODE_LEFT) ? 31'd0 : 31'd1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gjs_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = (item.mode == gjs_pkg::MODE_CLEAR) ? gjs_pkg::ST_RESP
						: gjs_pkg::ST_SCAN;
				end
			end
			gjs_pkg::ST_SCAN: begin
				if (!is_drain) begin
					if (lk_hit || scan_end) begin
						state_d = gjs_pkg::ST_RESP;
					end
				end else if (second) begin
					state_d = gjs_pkg::ST_MUL_GO;
				end else if (scan_end) begin
					state_d = (found_q || dr_match) ? gjs_pkg::ST_MUL_GO
						: gjs_pkg::ST_RESP;
				end
			end
			gjs_pkg::ST_MUL_GO: state_d = gjs_pkg::ST_MUL;
			gjs_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d = gjs_pkg::ST_RESP;
				end
			end
			gjs_pkg::ST_RESP: begin
				if (!out_valid_q || !result_stall) begin
					state_d = gjs_pkg::ST_IDLE;
				end
			end
			default: state_d = gjs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		wr_idx = rd_idx_q;
		wr_entry = mod_entry;
		item_stall = state_q != gjs_pkg::ST_IDLE;
		case (state_q)
			gjs_pkg::ST_SCAN: begin
				if (!is_drain) begin
					if (lk_hit) begin
						mem_we = 1'b1;
					end else if (scan_end && used_q != FULL) begin
						mem_we = 1'b1;
						wr_idx = used_q;
						wr_entry = new_entry;
					end
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gjs_pkg::ST_IDLE;
			used_q <= '0;
			dp_q <= '0;
			out_valid_q <= 1'b0;
			rv_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == gjs_pkg::ST_RESP && (!out_valid_q || !result_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				gjs_pkg::ST_IDLE: begin
					rv_q <= 1'b0;
					found_q <= 1'b0;
					if (item_valid && item.mode == gjs_pkg::MODE_CLEAR) begin
						used_q <= '0;
						dp_q <= '0;
					end
				end
				gjs_pkg::ST_SCAN: begin
					rv_q <= !scan_end;
					if (!is_drain) begin
						if (!lk_hit && scan_end && used_q != FULL) begin
							used_q <= used_q + 1'b1;
						end
					end else begin
						if (dr_match && !found_q) begin
							found_q <= 1'b1;
							dp_q <= rd_idx_q + 1'b1;
						end
						if (scan_end && !second && !found_q && !dr_match) begin
							dp_q <= used_q;
						end
					end
				end
				default: rv_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gjs_pkg::ST_IDLE: begin
				req_q <= item;
				scan_idx_q <= (item.mode == gjs_pkg::MODE_DRAIN) ? dp_q : '0;
				res_q <= '0;
			end
			gjs_pkg::ST_SCAN: begin
				rd_idx_q <= scan_idx_q;
				if (!scan_end) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (!is_drain) begin
					if (!lk_hit && scan_end && used_q == FULL) begin
						res_q.status <= gjs_pkg::STAT_FULL;
					end
				end else begin
					if (dr_match && !found_q) begin
						hit_q <= rd_entry;
					end
					if (second) begin
						res_q.last <= 1'b0;
					end else if (scan_end) begin
						if (found_q || dr_match) begin
							res_q.last <= 1'b1;
						end else begin
							res_q.status <= gjs_pkg::STAT_NONE;
						end
					end
				end
			end
			gjs_pkg::ST_MUL: begin
				if (mul_done) begin
					res_q.status <= gjs_pkg::STAT_GROUP;
					res_q.group_key <= hit_q.key;
					res_q.group_total <= mul_product;
				end
			end
			gjs_pkg::ST_RESP: begin
				if (!out_valid_q || !result_stall) begin
					out_q <= res_q;
				end
			end
			default: rd_idx_q <= rd_idx_q;
		endcase
	end

	gjs_table_mem #(
		.DEPTH(TABLE_ENTRIES),
		.AW(IW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(wr_idx[IW-1:0]),
		.wdata(wr_entry),
		.raddr(scan_idx_q[IW-1:0]),
		.rdata(rd_entry)
	);

	gjs_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.sum(hit_q.sum),
		.count(hit_q.count),
		.done(mul_done),
		.product(mul_product)
	);

	assign result_valid = out_valid_q;
	assign result = out_q;

	`ASSERT_ALWAYS(a_used_bound, clk, arst_n, used_q <= FULL)
	`ASSERT_ALWAYS(a_dp_bound, clk, arst_n, dp_q <= used_q)
	`ASSERT_IMPLIES(a_wr_in_use, clk, arst_n, mem_we, wr_idx <= used_q && wr_idx < FULL)
	`ASSERT_IMPLIES(a_mul_done_state, clk, arst_n, mul_done, state_q == gjs_pkg::ST_MUL)
	`ASSERT_NEXT(a_resp_loads, clk, arst_n,
		state_q == gjs_pkg::ST_RESP && state_d == gjs_pkg::ST_IDLE, out_valid_q)

endmodule
`default_nettype wire

### hw/rtl/gjs_table_mem.sv
`default_nettype none
module gjs_table_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire gjs_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output gjs_pkg::entry_t      rdata
);

	gjs_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hw/rtl/gjs_mul.sv
`default_nettype none
module gjs_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] sum,
	input  wire logic [30:0] count,
	output logic             done,
	output logic [63:0]      product
);

	gjs_pkg::mul_phase_t ph_q;
	logic [63:0] a_q;
	logic [30:0] b_q;
	logic [62:0] lo_q;
	logic [31:0] hi_q;
	logic [31:0] op;
	logic [62:0] prod;
	logic        done_q;

	assign op = (ph_q == gjs_pkg::MP_LO) ? a_q[31:0] : a_q[63:32];
	assign prod = {31'd0, op} * {32'd0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= gjs_pkg::MP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				gjs_pkg::MP_IDLE: begin
					if (start) begin
						ph_q <= gjs_pkg::MP_LO;
					end
				end
				gjs_pkg::MP_LO: ph_q <= gjs_pkg::MP_HI;
				gjs_pkg::MP_HI: begin
					ph_q <= gjs_pkg::MP_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= gjs_pkg::MP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && ph_q == gjs_pkg::MP_IDLE) begin
			a_q <= sum;
			b_q <= count;
		end
		if (ph_q == gjs_pkg::MP_LO) begin
			lo_q <= prod;
		end
		if (ph_q == gjs_pkg::MP_HI) begin
			hi_q <= prod[31:0];
		end
	end

	assign done = done_q;
	assign product = {1'b0, lo_q} + {hi_q, 32'd0};

endmodule
`default_nettype wire
